/* rtl/rdps_pkg.sv */
`timescale 1ns / 1ps
package rdps_pkg;
  localparam int TimeW = 52;
  localparam int SecW = 32;
  localparam int OrdW = 20;
  localparam int TagW = SecW + OrdW;
  localparam logic [1:0] RegStart = 2'd0;
  localparam logic [1:0] RegRate = 2'd1;
  localparam logic [1:0] RegThresh = 2'd2;
  localparam logic [1:0] RegWeight = 2'd3;
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIV, S_TIME, S_POP, S_FIND, S_INS, S_ADV, S_MOD
  } state_t;
endpackage

/* rtl/random_delay_packet_scheduler.sv */
`timescale 1ns / 1ps
// channel  direction  handshake           payload
// in       in         in_valid/in_stall   random_sample
// out      out        out_valid/out_stall send_second, send_order, last
// cfg      in         cfg_valid/cfg_ready cfg_index, cfg_data
// After the accepting edge the block stays busy while it divides, releases every
// due packet, waits out output stalls, shifts entries on insert when the packet is
// held, and, when the order sits at or above the rate, reduces it on the divider. The 52-step
// shared divider sets the floor.
// Held entries stay sorted in a register file; inserts shift one entry a cycle.
// Reset (rst, synchronous) restores the register defaults and empties the store.
// A stalled result holds the block in the release step.
module random_delay_packet_scheduler #(
  parameter int HEAP_DEPTH = 32,
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] random_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] send_second,
  output logic [19:0] send_order,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int TW = rdps_pkg::TimeW;
  localparam logic [TW-1:0] Ticks = TW'(TICKS_PER_SECOND);

  logic [31:0] slot_second;
  logic [19:0] rate, slot_order;
  logic [15:0] thresh, sample;
  logic [7:0]  weight;
  logic [CW-1:0] cnt, pos;
  logic [TW-1:0] rel [HEAP_DEPTH];
  logic [rdps_pkg::TagW-1:0] tag [HEAP_DEPTH];
  logic [TW-1:0] now, acc, quo, rem, newrel;
  logic [5:0] step;
  rdps_pkg::state_t state, state_next;

  logic [19:0] rate_eff;
  logic [TW-1:0] rem_sh, rem_sub, rem_nx;
  logic hit;
  assign rate_eff = (rate == '0) ? 20'd1 : rate;
  assign rem_sh = {rem[TW-2:0], acc[TW-1]};
  assign rem_sub = rem_sh - TW'(rate_eff);
  assign rem_nx = (rem_sub[TW-1] && !rem_sh[TW-1]) ? rem_sh : rem_sub;
  assign hit = (cnt != '0) && (rel[0] <= now);

  assign cfg_ready = (state == rdps_pkg::S_IDLE);
  assign in_stall = (state != rdps_pkg::S_IDLE);
  assign out_valid = (state == rdps_pkg::S_POP) && hit;
  assign send_second = tag[0][rdps_pkg::TagW-1:rdps_pkg::OrdW];
  assign send_order = tag[0][rdps_pkg::OrdW-1:0];
  assign last = (cnt == CW'(1)) || (rel[1] > now);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rdps_pkg::S_IDLE: if (in_valid) state_next = rdps_pkg::S_MUL;
      rdps_pkg::S_MUL: state_next = rdps_pkg::S_DIV;
      rdps_pkg::S_DIV: if (step == 6'(TW - 1)) state_next = rdps_pkg::S_TIME;
      rdps_pkg::S_TIME: state_next = rdps_pkg::S_POP;
      rdps_pkg::S_POP: begin
        if (!hit) state_next = (sample < thresh && cnt != CW'(HEAP_DEPTH)) ?
                               rdps_pkg::S_FIND : rdps_pkg::S_ADV;
      end
      rdps_pkg::S_FIND: if (pos == '0 || rel[IW'(pos - CW'(1))] <= newrel)
                          state_next = rdps_pkg::S_INS;
      rdps_pkg::S_INS: state_next = rdps_pkg::S_ADV;
      rdps_pkg::S_ADV: begin
        if (32'(slot_order) + 32'd1 > 32'(rate_eff)) state_next = rdps_pkg::S_MOD;
        else state_next = rdps_pkg::S_IDLE;
      end
      rdps_pkg::S_MOD: if (step == 6'd20) state_next = rdps_pkg::S_IDLE;
      default: state_next = rdps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_second <= '0; slot_order <= '0;
      rate <= 20'd1000; thresh <= 16'd10551; weight <= 8'd51; cnt <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rdps_pkg::RegStart: slot_second <= cfg_data;
          rdps_pkg::RegRate: rate <= cfg_data[19:0];
          rdps_pkg::RegThresh: thresh <= cfg_data[15:0];
          rdps_pkg::RegWeight: weight <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (state)
        rdps_pkg::S_IDLE: if (in_valid) sample <= random_sample;
        rdps_pkg::S_MUL: begin
          acc <= TW'(TICKS_PER_SECOND) * TW'(slot_order);
          now <= TW'(slot_second) * Ticks;
          rem <= '0; step <= 6'd0;
        end
        rdps_pkg::S_DIV: begin
          // restoring divide, 52 quotient bits, one per cycle
          acc <= {acc[TW-2:0], ~rem_sub[TW-1] | rem_sh[TW-1]};
          rem <= rem_nx;
          step <= step + 6'd1;
        end
        rdps_pkg::S_TIME: begin
          now <= now + acc;
          newrel <= now + acc + TW'((32'(sample) * 32'(weight)) >> 12);
        end
        rdps_pkg::S_POP: begin
          if (hit && !out_stall) begin
            for (int k = 0; k < HEAP_DEPTH - 1; k++) begin
              rel[k] <= rel[k+1]; tag[k] <= tag[k+1];
            end
            cnt <= cnt - CW'(1);
          end
          pos <= cnt - CW'(hit && !out_stall);
        end
        rdps_pkg::S_FIND: begin
          if (!(pos == '0 || rel[IW'(pos - CW'(1))] <= newrel)) begin
            rel[IW'(pos)] <= rel[IW'(pos - CW'(1))];
            tag[IW'(pos)] <= tag[IW'(pos - CW'(1))];
            pos <= pos - CW'(1);
          end
        end
        rdps_pkg::S_INS: begin
          rel[IW'(pos)] <= newrel;
          tag[IW'(pos)] <= {slot_second, slot_order};
          cnt <= cnt + CW'(1);
        end
        rdps_pkg::S_ADV: begin
          if (32'(slot_order) + 32'd1 > 32'(rate_eff)) begin
            // order at or above the rate: reduce order + 1 on the shared divider
            acc <= {21'(slot_order) + 21'd1, {(TW-21){1'b0}}};
            rem <= '0; step <= 6'd0;
          end else if (32'(slot_order) + 32'd1 == 32'(rate_eff)) begin
            slot_order <= '0; slot_second <= slot_second + 32'd1;
          end else begin
            slot_order <= slot_order + 20'd1;
          end
        end
        rdps_pkg::S_MOD: begin
          acc <= {acc[TW-2:0], ~rem_sub[TW-1] | rem_sh[TW-1]};
          rem <= rem_nx;
          step <= step + 6'd1;
          if (step == 6'd20) begin
            slot_order <= rem_nx[19:0];
            if (rem_nx == '0) slot_second <= slot_second + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(HEAP_DEPTH))
    else $error("store overflow");
  assert property (@(posedge clk) disable iff (rst)
    state == rdps_pkg::S_INS |=> cnt == $past(cnt) + CW'(1))
    else $error("insert count");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cnt != '0)
    else $error("release from empty store");
endmodule
